[rtl/rpc_pkg.sv]
// Shared types and constants for the relative permutation code block.
package rpc_pkg;

	localparam int FIELD_W     = 6;
	localparam int TABLE_DEPTH = 64;
	localparam int MAX_LEN_DEF = 64;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PROC = 1'b1
	} op_t;

	typedef struct packed {
		logic               action;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] code;
		logic               code_last;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] value;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

[rtl/rpc_front.sv]
// Front end: takes items, decodes the operation and queues them for the back end.
module rpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rpc_pkg::in_item_t    item,
	input  logic                 pop,
	output rpc_pkg::queue_head_t head
);
	import rpc_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;

	assign busy = (cnt_q == 2'd2);
	assign push = start & ~busy;

	always_comb begin
		cmd_in.op    = item.action ? OP_PROC : OP_LOAD;
		cmd_in.index = item.index;
		cmd_in.value = item.value;
		cmd_in.last  = item.last;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/rpc_back.sv]
// Back end: rank table, rank history and the serial count of smaller earlier ranks.
module rpc_back #(
	parameter int MAX_LEN = rpc_pkg::MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rpc_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 strobe,
	output rpc_pkg::out_item_t   result
);
	import rpc_pkg::*;

	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_COUNT  = 3'b010,
		ST_FINISH = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [FIELD_W-1:0] rank_mem [TABLE_DEPTH];
	logic [FIELD_W-1:0] hist_mem [MAX_LEN];
	logic [FIELD_W-1:0] rank_q;
	logic [FIELD_W-1:0] hist_s1;
	logic               cmp_v_s1;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      j_q;
	logic [PW-1:0]      cnt_q;
	logic               last_q;
	logic               strobe_q;
	out_item_t          result_q;
	logic               issue;
	logic               hist_full;
	logic [CW-1:0]      rank_ext;
	logic [CW-1:0]      cnt_ext;
	logic [FIELD_W-1:0] code_val;

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign issue     = (state_q == ST_COUNT) && (j_q != pos_q);
	assign hist_full = (pos_q == PW'(MAX_LEN));
	assign strobe    = strobe_q;
	assign result    = result_q;

	assign rank_ext = CW'(rank_q);
	assign cnt_ext  = CW'(cnt_q);
	// repeated ranks can count past the rank itself: clamp at zero
	assign code_val = (cnt_ext > rank_ext) ? '0 : FIELD_W'(rank_ext - cnt_ext);

	always_ff @(posedge clk) begin
		if (pop && head.cmd.op == OP_LOAD) begin
			rank_mem[head.cmd.index] <= head.cmd.value;
		end
		if (pop && head.cmd.op == OP_PROC) begin
			rank_q <= rank_mem[head.cmd.value];
			last_q <= head.cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hist_s1 <= hist_mem[j_q[IW-1:0]];
		end
		if (state_q == ST_FINISH && !hist_full) begin
			hist_mem[pos_q[IW-1:0]] <= rank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			result_q.code      <= code_val;
			result_q.code_last <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			cmp_v_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			cmp_v_s1 <= issue;
			strobe_q <= 1'b0;
			if (cmp_v_s1 && hist_s1 < rank_q) begin
				cnt_q <= cnt_q + PW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.cmd.op == OP_PROC) begin
						j_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (issue) begin
						j_q <= j_q + PW'(1);
					end else if (!cmp_v_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					strobe_q <= 1'b1;
					if (last_q) begin
						pos_q <= '0;
					end else if (!hist_full) begin
						pos_q <= pos_q + PW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/relative_permutation_code.sv]
// Relative permutation code: Lehmer-style code of a sequence through a rank table.
//
// Input: an item is transferred at a clock edge with start high and busy low.
// action = 0 writes rank table entry index with value (no result).
// action = 1 looks up the rank of value, emits the rank minus the number of
// smaller ranks already seen in the sequence, and appends the rank to the
// history; last = 1 ends the sequence and empties the history.
// Items go into a two-entry queue; busy is high while that queue is full.
// Output: each result is shown on result for one cycle with strobe high;
// the receiver cannot stall, so there is no backpressure on this side.
// Steps: a load item writes the rank table as it leaves the queue. A process item
// goes through ST_COUNT, which compares the P ranks in the history with its rank,
// then ST_FINISH, which shows the result. P is at most MAX_LEN; the history memory
// is scanned one entry per cycle through its single read port.
// Reset: the history is empty and the queue is drained; the rank table
// keeps no reset value and must be loaded before use.
module relative_permutation_code #(
	parameter int MAX_LEN = rpc_pkg::MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rpc_pkg::in_item_t  item,
	output logic               strobe,
	output rpc_pkg::out_item_t result
);
	import rpc_pkg::*;

	queue_head_t head;
	logic        pop;

	rpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.pop    (pop),
		.head   (head)
	);

	rpc_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

[rtl/rpc_checker.sv]
// Port-level checks for the relative permutation code block, bound to the top level.
module rpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               strobe,
	input rpc_pkg::out_item_t result
);
	import rpc_pkg::*;

	// a result is followed by a gap with strobe low, never by another result
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe ##1 !strobe)
		else $error("strobe repeated too soon");

	// the queue only fills through a transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

	// the queue drains only while the back end is idle, never with a result out
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> !strobe)
		else $error("busy fell while a result was shown");

	// a result never carries an unknown last flag
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !$isunknown(result.code_last))
		else $error("result last flag unknown");

endmodule

bind relative_permutation_code rpc_checker u_rpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
